// ===== design/multi_channel_running_stats_top_macros.svh =====
// ----------------------------------------------------------------------------
// Running statistics assertion macros
// Concurrent check macros shared by the running statistics block.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_RUNNING_STATS_TOP_MACROS_SVH
`define MULTI_CHANNEL_RUNNING_STATS_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MCRS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("running stats check failed");
`define MCRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("running stats check failed");
`else
`define MCRS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MCRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/mcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Running statistics package
// Shared widths, codes, entry layout and helper types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrs_pkg;

    localparam int MAX_OBS   = 64;
    localparam int IDX_W     = $clog2(MAX_OBS);
    localparam int FRAC_BITS = 16;
    localparam int ACT_W     = 7;

    localparam logic [1:0] REQ_REAL    = 2'd0;
    localparam logic [1:0] REQ_COMPLEX = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_CLR   = 2'd2;

    typedef struct packed {
        logic [63:0] im2;
        logic [31:0] imean;
        logic [31:0] icnt;
        logic [63:0] rm2;
        logic [31:0] rmean;
        logic [31:0] rcnt;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/mcrs_div.sv =====
// ----------------------------------------------------------------------------
// Running statistics divider
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrs_div
    import mcrs_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEPS  = 64;
    localparam int STEP_W = $clog2(STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [31:0]       rem_reg;
    logic [63:0]       quo_reg;
    logic [31:0]       dvs_reg;

    logic [32:0] trial;
    logic [33:0] diff;
    logic        ge;
    logic [31:0] rem_next;
    logic [63:0] quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[63]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        ge       = !diff[33];
        rem_next = ge ? diff[31:0] : trial[31:0];
        quo_next = {quo_reg[62:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/mcrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// Running statistics square root
// Digit-by-digit integer square root of a 64-bit value, one digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrs_sqrt
    import mcrs_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] val_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;

    logic [63:0] trial;
    logic        ge;

    always_comb begin
        trial = res_reg + bit_reg;
        ge    = val_reg >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            val_reg <= req.radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end else if (busy_reg) begin
            if (ge) begin
                val_reg <= val_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

endmodule

`default_nettype wire

// ===== design/multi_channel_running_stats_top.sv =====
// ----------------------------------------------------------------------------
// Multi-channel running statistics
// Per-observable Welford mean and variance kept in an on-chip store.
//
//   Channel | Direction | Handshake        | Content
//   s_      | in        | s_tvalid/tready  | request, index, complex sample
//   m_      | out       | m_tvalid/tready  | status, means, variance, error
//   cfg_    | in        | cfg_valid/ready  | active observable count
//
// A clear request or an out-of-range index goes straight to S_OUT, which
// presents its result once the result channel is free. A record request
// presents its result after the shared 64-step divider, which runs up to
// six divisions, and the 32-step square root. Reset or a configuration
// write empties the store at once. A stalled result channel holds the
// block before it takes the next request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_running_stats_top_macros.svh"

module multi_channel_running_stats_top
    import mcrs_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [71:0]          s_tdata,  // obs_index, sample_real, sample_imag, pad
    input  wire  [1:0]           s_tuser,  // req_type
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [191:0]         m_tdata,  // index_echo, mean_real_out, mean_imag_out,
                                           // variance_sum, std_error_out,
                                           // completed_count, pad
    output logic [1:0]           m_tuser,  // status
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [ACT_W-1:0]     cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_LOAD   = 14'b00000000000010,
        S_MSTART = 14'b00000000000100,
        S_MWAIT  = 14'b00000000001000,
        S_MUL    = 14'b00000000010000,
        S_ACC    = 14'b00000000100000,
        S_WB     = 14'b00000001000000,
        S_VAR    = 14'b00000010000000,
        S_VWAIT  = 14'b00000100000000,
        S_SE     = 14'b00001000000000,
        S_SWAIT  = 14'b00010000000000,
        S_ROOT   = 14'b00100000000000,
        S_RWAIT  = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t            state_reg;
    logic [ACT_W-1:0]  active_reg;
    logic [31:0]       max_reg;
    logic              valid_reg [MAX_OBS];
    entry_t            mem_ram   [MAX_OBS];
    entry_t            rd_reg;

    logic [1:0]        req_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [31:0]       xr_reg;
    logic [31:0]       xi_reg;
    logic              part_reg;
    logic [1:0]        status_reg;
    logic [31:0]       cnt_reg  [2];
    logic [31:0]       mean_reg [2];
    logic [63:0]       m2_reg   [2];
    logic [63:0]       var_reg  [2];
    logic [31:0]       n_reg;
    logic [32:0]       delta_reg;
    logic [31:0]       ad_reg;
    logic [31:0]       nm_reg;
    logic [63:0]       prod_reg;
    logic [63:0]       se2_reg;
    logic [31:0]       root_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [31:0]       m_mr_reg;
    logic [31:0]       m_mi_reg;
    logic [55:0]       m_var_reg;
    logic [31:0]       m_se_reg;
    logic [31:0]       m_cc_reg;

    div_req_t          div_req;
    div_rsp_t          div_rsp;
    sqrt_req_t         sqrt_req;
    sqrt_rsp_t         sqrt_rsp;

    logic              accept_in;
    logic [1:0]        in_req;
    logic [IDX_W-1:0]  in_idx;
    logic              in_range;
    logic              rec_ok;
    logic              out_free;
    logic              clear_all;
    entry_t            entry_in;
    entry_t            entry_wr;

    logic [31:0]       x_sel;
    logic [31:0]       m_sel;
    logic [31:0]       cnt_sel;
    logic [31:0]       n_calc;
    logic [32:0]       delta_calc;
    logic [32:0]       delta_neg;
    logic [31:0]       ad_calc;
    logic [33:0]       q_ext;
    logic [33:0]       nm_calc;
    logic [32:0]       d2_calc;
    logic [32:0]       d2_neg;
    logic [31:0]       ad2_calc;
    logic [64:0]       m2_sum;
    logic [64:0]       vsum;
    logic [55:0]       vsum_sat;
    logic              last_part;

    assign accept_in = s_tvalid && s_tready;
    assign in_req    = s_tuser;
    assign in_idx    = s_tdata[IDX_W-1:0];
    assign in_range  = {1'b0, in_idx} < active_reg;
    assign rec_ok    = (in_req == REQ_REAL || in_req == REQ_COMPLEX) && in_range;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign last_part = part_reg || (req_reg != REQ_COMPLEX);
    assign clear_all = (cfg_valid && cfg_ready) || (accept_in && in_req == REQ_CLEAR);

    always_comb begin
        entry_in = valid_reg[idx_reg] ? rd_reg : '0;
        entry_wr = '{im2: m2_reg[1], imean: mean_reg[1], icnt: cnt_reg[1],
                     rm2: m2_reg[0], rmean: mean_reg[0], rcnt: cnt_reg[0]};
    end

    always_comb begin
        x_sel      = part_reg ? xi_reg : xr_reg;
        m_sel      = mean_reg[part_reg];
        cnt_sel    = cnt_reg[part_reg];
        n_calc     = (cnt_sel == '1) ? cnt_sel : cnt_sel + 32'd1;
        delta_calc = {x_sel[31], x_sel} - {m_sel[31], m_sel};
        delta_neg  = -delta_calc;
        ad_calc    = delta_calc[32] ? delta_neg[31:0] : delta_calc[31:0];
        q_ext      = {2'b00, div_rsp.quotient[31:0]};
        nm_calc    = {{2{m_sel[31]}}, m_sel} + (delta_reg[32] ? -q_ext : q_ext);
        d2_calc    = {x_sel[31], x_sel} - {nm_reg[31], nm_reg};
        d2_neg     = -d2_calc;
        ad2_calc   = d2_calc[32] ? d2_neg[31:0] : d2_calc[31:0];
        m2_sum     = {1'b0, m2_reg[part_reg]} + {1'b0, prod_reg >> FRAC_BITS};
        vsum       = {1'b0, var_reg[0]} + {1'b0, var_reg[1]};
        vsum_sat   = (vsum[64:56] != '0) ? '1 : vsum[55:0];
    end

    always_comb begin
        div_req = '0;
        case (state_reg)
            S_MSTART: begin
                div_req.start    = 1'b1;
                div_req.dividend = {32'd0, ad_calc};
                div_req.divisor  = n_calc;
            end
            S_VAR: begin
                div_req.start    = cnt_sel >= 32'd2;
                div_req.dividend = m2_reg[part_reg];
                div_req.divisor  = cnt_sel - 32'd1;
            end
            S_SE: begin
                div_req.start    = cnt_sel != '0;
                div_req.dividend = var_reg[part_reg];
                div_req.divisor  = cnt_sel;
            end
            default: begin
                div_req = '0;
            end
        endcase
        sqrt_req.start    = (state_reg == S_ROOT) && (se2_reg[63:64-FRAC_BITS] == '0);
        sqrt_req.radicand = se2_reg << FRAC_BITS;
    end

    mcrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    mcrs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    always_ff @(posedge aclk) begin
        rd_reg <= mem_ram[in_idx];
        if (state_reg == S_WB) begin
            mem_ram[idx_reg] <= entry_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= ACT_W'(MAX_OBS);
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_OBS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                active_reg <= cfg_data;
            end
            if (clear_all) begin
                max_reg <= '0;
                for (int i = 0; i < MAX_OBS; i++) begin
                    valid_reg[i] <= 1'b0;
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept_in) begin
                        if (in_req == REQ_CLEAR) begin
                            state_reg <= S_OUT;
                        end else if (in_req == REQ_NONE) begin
                            state_reg <= S_IDLE;
                        end else if (!in_range) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD:   state_reg <= S_MSTART;
                S_MSTART: state_reg <= S_MWAIT;
                S_MWAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_ACC;
                S_ACC: state_reg <= last_part ? S_WB : S_MSTART;
                S_WB: begin
                    valid_reg[idx_reg] <= 1'b1;
                    if (cnt_reg[0] > max_reg) begin
                        max_reg <= cnt_reg[0];
                    end
                    state_reg <= S_VAR;
                end
                S_VAR: begin
                    if (cnt_sel >= 32'd2) begin
                        state_reg <= S_VWAIT;
                    end else if (part_reg) begin
                        state_reg <= S_SE;
                    end
                end
                S_VWAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= part_reg ? S_SE : S_VAR;
                    end
                end
                S_SE: begin
                    if (cnt_sel != '0) begin
                        state_reg <= S_SWAIT;
                    end else if (part_reg) begin
                        state_reg <= S_ROOT;
                    end
                end
                S_SWAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= part_reg ? S_ROOT : S_SE;
                    end
                end
                S_ROOT: state_reg <= sqrt_req.start ? S_RWAIT : S_OUT;
                S_RWAIT: begin
                    if (sqrt_rsp.done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                req_reg  <= in_req;
                idx_reg  <= in_idx;
                xr_reg   <= s_tdata[IDX_W+31:IDX_W];
                xi_reg   <= s_tdata[IDX_W+63:IDX_W+32];
                part_reg <= 1'b0;
                if (in_req == REQ_CLEAR) begin
                    status_reg <= ST_CLR;
                end else if (!in_range) begin
                    status_reg <= ST_RANGE;
                end else begin
                    status_reg <= ST_OK;
                end
            end
            S_LOAD: begin
                cnt_reg[0]  <= entry_in.rcnt;
                mean_reg[0] <= entry_in.rmean;
                m2_reg[0]   <= entry_in.rm2;
                cnt_reg[1]  <= entry_in.icnt;
                mean_reg[1] <= entry_in.imean;
                m2_reg[1]   <= entry_in.im2;
            end
            S_MSTART: begin
                n_reg     <= n_calc;
                delta_reg <= delta_calc;
                ad_reg    <= ad_calc;
            end
            S_MWAIT: begin
                if (div_rsp.done) begin
                    nm_reg <= nm_calc[31:0];
                end
            end
            S_MUL: begin
                prod_reg <= ad_reg * ad2_calc;
            end
            S_ACC: begin
                m2_reg[part_reg]   <= m2_sum[64] ? '1 : m2_sum[63:0];
                cnt_reg[part_reg]  <= n_reg;
                mean_reg[part_reg] <= nm_reg;
                if (!last_part) begin
                    part_reg <= 1'b1;
                end
            end
            S_WB: begin
                part_reg <= 1'b0;
            end
            S_VAR: begin
                if (cnt_sel < 32'd2) begin
                    var_reg[part_reg] <= '0;
                    part_reg          <= !part_reg;
                    se2_reg           <= '0;
                end
            end
            S_VWAIT: begin
                if (div_rsp.done) begin
                    var_reg[part_reg] <= div_rsp.quotient;
                    part_reg          <= !part_reg;
                    se2_reg           <= '0;
                end
            end
            S_SE: begin
                if (cnt_sel == '0) begin
                    part_reg <= !part_reg;
                end
            end
            S_SWAIT: begin
                if (div_rsp.done) begin
                    se2_reg  <= add_sat64(se2_reg, div_rsp.quotient);
                    part_reg <= !part_reg;
                end
            end
            S_ROOT: begin
                if (!sqrt_req.start) begin
                    root_reg <= '1;
                end
            end
            S_RWAIT: begin
                if (sqrt_rsp.done) begin
                    root_reg <= sqrt_rsp.root;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_status_reg <= status_reg;
                    m_idx_reg    <= idx_reg;
                    if (status_reg == ST_OK) begin
                        m_mr_reg  <= mean_reg[0];
                        m_mi_reg  <= mean_reg[1];
                        m_var_reg <= vsum_sat;
                        m_se_reg  <= root_reg;
                        m_cc_reg  <= max_reg;
                    end else begin
                        m_mr_reg  <= '0;
                        m_mi_reg  <= '0;
                        m_var_reg <= '0;
                        m_se_reg  <= '0;
                        m_cc_reg  <= '0;
                    end
                end
            end
            default: begin
                part_reg <= part_reg;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_cc_reg, m_se_reg, m_var_reg, m_mi_reg, m_mr_reg, m_idx_reg};

    `MCRS_ASSERT_NOW(a_err_fields_zero, aclk, aresetn, m_valid_reg && (m_status_reg != ST_OK), (m_var_reg == '0) && (m_se_reg == '0) && (m_cc_reg == '0))
    `MCRS_ASSERT_NOW(a_div_start_idle, aclk, aresetn, div_req.start, !div_rsp.busy)
    `MCRS_ASSERT_NEXT(a_record_loads, aclk, aresetn, accept_in && rec_ok, state_reg == S_LOAD)

endmodule

`default_nettype wire
